FILE: hdl/ram_link_transfer_framer_macros.svh
// Assertion macros used by the framer top level.
`ifndef RAM_LINK_TRANSFER_FRAMER_MACROS_SVH
`define RAM_LINK_TRANSFER_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define RLTF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");
`define RLTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");
`else
`define RLTF_ASSERT_SAME(label, clk, rst, ante, cons)
`define RLTF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/rltf_pkg.sv
// Package with types, codes and tables of the RAM link transfer framer.
`default_nettype none
package rltf_pkg;
   localparam int CMD_W  = 2;
   localparam int OP_W   = 3;
   localparam int KIND_W = 2;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RECV  = 2'd2;

   localparam logic [OP_W-1:0] OP_TEST   = 3'd0;
   localparam logic [OP_W-1:0] OP_RBYTE  = 3'd1;
   localparam logic [OP_W-1:0] OP_WBYTE  = 3'd2;
   localparam logic [OP_W-1:0] OP_RBLOCK = 3'd3;
   localparam logic [OP_W-1:0] OP_WBLOCK = 3'd4;

   localparam logic [KIND_W-1:0] KIND_LINK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

   localparam logic [7:0] OPCODE_TABLE [5] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
   localparam logic [8:0] MOD_FLETCHER = 9'd255;

   localparam int TEST_REPLY_LEN_DEF = 6;
   localparam int MAX_BEATS   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        out_byte;
      logic [15:0]       position;
      logic              ok;
   } beat_type;

   typedef struct packed {
      logic [2:0]                   count;
      beat_type [MAX_BEATS-1:0]     beats;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;
endpackage
`default_nettype wire

FILE: hdl/rltf_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface rltf_req_if;
   logic                      valid;
   logic                      ready;
   logic [rltf_pkg::CMD_W-1:0] command;
   logic [rltf_pkg::OP_W-1:0]  operation;
   logic [15:0]               address;
   logic [15:0]               length;
   logic [7:0]                byte_value;

   modport source (output valid, command, operation, address, length, byte_value,
                   input ready);
   modport sink   (input valid, command, operation, address, length, byte_value,
                   output ready);
endinterface

interface rltf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rltf_pkg::KIND_W-1:0] kind;
   logic [7:0]                  out_byte;
   logic [15:0]                 position;
   logic                        ok;
   logic                        last;

   modport source (output valid, kind, out_byte, position, ok, last, input ready);
   modport sink   (input valid, kind, out_byte, position, ok, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/rltf_front.sv
// Front part: accepts request beats, runs the transfer phases and emits jobs.
`default_nettype none
module rltf_front #(
   parameter int TEST_REPLY_LEN = rltf_pkg::TEST_REPLY_LEN_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   rltf_req_if.sink            req,
   input  wire rltf_pkg::q_status_type q_status,
   output rltf_pkg::push_type  push
);
   import rltf_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_REPLY  = 3'd1;
   localparam logic [2:0] PH_REPLY2 = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_CS1    = 3'd4;
   localparam logic [2:0] PH_CS2    = 3'd5;

   localparam logic [16:0] TEST_LAST = 17'(TEST_REPLY_LEN);

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  sum_lo_ff, sum_lo_in;
   logic [7:0]  sum_hi_ff, sum_hi_in;
   logic [7:0]  first_ff, first_in;

   logic       accept;
   logic [8:0] lo_raw, hi_raw;
   logic [7:0] lo_next, hi_next;

   function automatic beat_type mk_beat(input logic [KIND_W-1:0] kind,
                                        input logic [7:0] b,
                                        input logic [15:0] pos,
                                        input logic ok);
      beat_type r;
      r.kind     = kind;
      r.out_byte = b;
      r.position = pos;
      r.ok       = ok;
      return r;
   endfunction

   function automatic job_type header_job(input logic [OP_W-1:0] op,
                                          input logic [15:0] addr,
                                          input logic [15:0] len);
      job_type j;
      j = '0;
      j.beats[0] = mk_beat(KIND_LINK, OPCODE_TABLE[op], 16'd0, 1'b0);
      j.beats[1] = mk_beat(KIND_LINK, addr[7:0], 16'd0, 1'b0);
      j.beats[2] = mk_beat(KIND_LINK, addr[15:8], 16'd0, 1'b0);
      j.beats[3] = mk_beat(KIND_LINK, len[7:0], 16'd0, 1'b0);
      j.beats[4] = mk_beat(KIND_LINK, len[15:8], 16'd0, 1'b0);
      if (op == OP_TEST) begin
         j.count = 3'd1;
      end else if (op == OP_RBLOCK || op == OP_WBLOCK) begin
         j.count = 3'd5;
      end else begin
         j.count = 3'd3;
      end
      return j;
   endfunction

   function automatic job_type single_job(input beat_type b);
      job_type j;
      j = '0;
      j.count    = 3'd1;
      j.beats[0] = b;
      return j;
   endfunction

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   // Fletcher-16 step: both running sums stay below 255, so one subtract suffices.
   always_comb begin
      lo_raw  = {1'b0, sum_lo_ff} + {1'b0, req.byte_value};
      lo_next = (lo_raw >= MOD_FLETCHER) ? 8'(lo_raw - MOD_FLETCHER) : lo_raw[7:0];
      hi_raw  = {1'b0, sum_hi_ff} + {1'b0, lo_next};
      hi_next = (hi_raw >= MOD_FLETCHER) ? 8'(hi_raw - MOD_FLETCHER) : hi_raw[7:0];
   end

   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      index_in  = index_ff;
      sum_lo_in = sum_lo_ff;
      sum_hi_in = sum_hi_ff;
      first_in  = first_ff;
      push      = '0;
      if (accept) begin
         case (req.command)
            CMD_START: begin
               if (phase_ff == PH_IDLE && req.operation <= OP_WBLOCK) begin
                  op_in     = req.operation;
                  addr_in   = req.address;
                  left_in   = req.length;
                  index_in  = '0;
                  sum_lo_in = '0;
                  sum_hi_in = '0;
                  first_in  = '0;
                  push.push = 1'b1;
                  push.job  = header_job(req.operation, req.address, req.length);
                  if (req.operation == OP_WBYTE) begin
                     push.job.beats[3] = mk_beat(KIND_LINK, req.byte_value, 16'd0, 1'b0);
                     push.job.count    = 3'd4;
                  end
                  if (req.operation == OP_RBLOCK || req.operation == OP_WBLOCK) begin
                     phase_in = (req.length == 16'd0) ? PH_CS1 : PH_DATA;
                  end else begin
                     phase_in = PH_REPLY;
                  end
               end
            end
            CMD_SEND: begin
               if (phase_ff == PH_DATA && op_ff == OP_WBLOCK) begin
                  push.push = 1'b1;
                  push.job  = single_job(mk_beat(KIND_LINK, req.byte_value, index_ff, 1'b0));
                  sum_lo_in = lo_next;
                  sum_hi_in = hi_next;
                  index_in  = index_ff + 16'd1;
                  left_in   = left_ff - 16'd1;
                  if (left_ff == 16'd1) begin
                     phase_in = PH_CS1;
                  end
               end
            end
            CMD_RECV: begin
               case (phase_ff)
                  PH_REPLY: begin
                     if (op_ff == OP_TEST) begin
                        push.push = 1'b1;
                        if ({1'b0, index_ff} + 17'd1 >= TEST_LAST) begin
                           // Final test reply is delivered as zero and closes the operation.
                           push.job = '0;
                           push.job.count    = 3'd2;
                           push.job.beats[0] = mk_beat(KIND_DELIVER, 8'd0, index_ff, 1'b0);
                           push.job.beats[1] = mk_beat(KIND_DONE, 8'd0, 16'd0, 1'b1);
                           phase_in = PH_IDLE;
                        end else begin
                           push.job = single_job(mk_beat(KIND_DELIVER, req.byte_value,
                                                         index_ff, 1'b0));
                           index_in = index_ff + 16'd1;
                        end
                     end else if (op_ff == OP_RBYTE) begin
                        first_in = req.byte_value;
                        phase_in = PH_REPLY2;
                     end else begin
                        push.push = 1'b1;
                        push.job  = single_job(mk_beat(KIND_DONE, req.byte_value, 16'd0, 1'b1));
                        phase_in  = PH_IDLE;
                     end
                  end
                  PH_REPLY2: begin
                     push.push = 1'b1;
                     if (req.byte_value == first_ff) begin
                        push.job = single_job(mk_beat(KIND_DONE, req.byte_value, 16'd0, 1'b1));
                        phase_in = PH_IDLE;
                     end else begin
                        // The two copies disagree, so the request header goes out again.
                        push.job = header_job(op_ff, addr_ff, left_ff);
                        phase_in = PH_REPLY;
                     end
                  end
                  PH_DATA: begin
                     if (op_ff == OP_RBLOCK) begin
                        push.push = 1'b1;
                        push.job  = single_job(mk_beat(KIND_DELIVER, req.byte_value,
                                                       index_ff, 1'b0));
                        sum_lo_in = lo_next;
                        sum_hi_in = hi_next;
                        index_in  = index_ff + 16'd1;
                        left_in   = left_ff - 16'd1;
                        if (left_ff == 16'd1) begin
                           phase_in = PH_CS1;
                        end
                     end
                  end
                  PH_CS1: begin
                     first_in = req.byte_value;
                     phase_in = PH_CS2;
                  end
                  PH_CS2: begin
                     push.push = 1'b1;
                     push.job  = single_job(mk_beat(KIND_DONE, 8'd0, 16'd0,
                        sum_lo_ff == first_ff && sum_hi_ff == req.byte_value));
                     phase_in  = PH_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         op_ff     <= '0;
         addr_ff   <= '0;
         left_ff   <= '0;
         index_ff  <= '0;
         sum_lo_ff <= '0;
         sum_hi_ff <= '0;
         first_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         addr_ff   <= addr_in;
         left_ff   <= left_in;
         index_ff  <= index_in;
         sum_lo_ff <= sum_lo_in;
         sum_hi_ff <= sum_hi_in;
         first_ff  <= first_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/rltf_queue.sv
// Short job queue between the front and back parts.
`default_nettype none
module rltf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rltf_pkg::push_type push,
   input  wire logic              pop,
   output rltf_pkg::job_type      head,
   output rltf_pkg::q_status_type status
);
   import rltf_pkg::*;

   job_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slots_ff[rd_ptr_ff];
   assign do_push      = push.push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/rltf_back.sv
// Back part: expands queued jobs into response beats through an output register.
`default_nettype none
module rltf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rltf_pkg::job_type head,
   input  wire rltf_pkg::q_status_type q_status,
   output logic                   pop,
   rltf_rsp_if.source             rsp
);
   import rltf_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   beat_type    beat_ff, beat_in;
   logic        last_ff, last_in;
   logic        load, head_last;

   assign load      = !valid_ff || rsp.ready;
   assign head_last = (idx_ff == head.count - 3'd1);
   assign pop       = load && !q_status.empty && head_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            beat_in = head.beats[idx_ff];
            last_in = head_last;
            idx_in  = head_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.kind     = beat_ff.kind;
   assign rsp.out_byte = beat_ff.out_byte;
   assign rsp.position = beat_ff.position;
   assign rsp.ok       = beat_ff.ok;
   assign rsp.last     = last_ff;
endmodule
`default_nettype wire

FILE: hdl/ram_link_transfer_framer.sv
// Path: with the queue empty and the output register free, the first response beat of a
// request beat is written into a job queue slot and then loaded into the output register.
// Throughput: one request beat per cycle while the job queue is not full; the n response
// beats of a request leave the output register one by one, and a four-entry job queue
// absorbs header bursts. Request beats that cause no response enter no queue entry.
// Reset is synchronous: it clears the transfer phase, the running sums, the queue pointers
// and the output valid; no clearing pass is needed.
`default_nettype none
`include "ram_link_transfer_framer_macros.svh"
module ram_link_transfer_framer #(
   parameter int TEST_REPLY_LEN = rltf_pkg::TEST_REPLY_LEN_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rltf_req_if.sink   req_chan,
   rltf_rsp_if.source rsp_chan
);
   import rltf_pkg::*;

   push_type     push;
   job_type      head;
   q_status_type q_status;
   logic         pop;

   rltf_front #(
      .TEST_REPLY_LEN(TEST_REPLY_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_status (q_status),
      .push     (push)
   );

   rltf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   rltf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

   `RLTF_ASSERT_SAME(a_push_on_accept, clock, reset, push.push, req_chan.valid && req_chan.ready)
   `RLTF_ASSERT_SAME(a_queue_sane, clock, reset, 1'b1, !(q_status.full && q_status.empty))
   `RLTF_ASSERT_NEXT(a_push_fills, clock, reset, push.push, !q_status.empty)
   `RLTF_ASSERT_SAME(a_pop_on_load, clock, reset, pop, !q_status.empty)
endmodule
`default_nettype wire

FILE: bench/ram_link_transfer_framer_tb.sv
// Self-checking testbench for the RAM link transfer framer, predicting every response beat.
module ram_link_transfer_framer_tb;
   import rltf_pkg::*;

   localparam int REPLY_COUNT  = TEST_REPLY_LEN_DEF;
   localparam int MAX_GAP      = 17;
   localparam int FLETCHER_MOD = 255;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_BEATS = 50;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [OP_W-1:0]  OP_HIGHEST = 3'd7;

   typedef enum logic [2:0] {
      LINK_IDLE,
      AWAIT_REPLY,
      AWAIT_ECHO,
      BLOCK_DATA,
      AWAIT_SUM_LO,
      AWAIT_SUM_HI
   } link_phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        out_byte;
      logic [15:0]       position;
      logic              ok;
      logic              last;
   } rsp_beat_type;

   logic clock;
   logic reset;

   rltf_req_if req_chan();
   rltf_rsp_if rsp_chan();

   ram_link_transfer_framer #(.TEST_REPLY_LEN(REPLY_COUNT)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted state of the transfer in progress.
   link_phase_type  fr_phase;
   logic [OP_W-1:0] fr_op;
   logic [15:0]     fr_address;
   logic [15:0]     fr_left;
   logic [15:0]     fr_index;
   logic [7:0]      fr_sum_lo;
   logic [7:0]      fr_sum_hi;
   logic [7:0]      fr_held;

   rsp_beat_type awaited_rsp[$];
   rsp_beat_type beat_batch[$];

   bit tx_gapless;
   bit rx_gapless;
   int rx_hold;
   int beats_sent;
   int effective_beats;
   int beats_checked;
   int failure_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[ram_link_transfer_framer] ERROR");
      $finish;
   end

   function automatic void emit_beat(input logic [KIND_W-1:0] kind, input logic [7:0] value,
                                     input logic [15:0] pos, input logic ok_flag);
      rsp_beat_type beat;
      beat.kind     = kind;
      beat.out_byte = value;
      beat.position = pos;
      beat.ok       = ok_flag;
      beat.last     = 1'b0;
      beat_batch.push_back(beat);
   endfunction

   function automatic void emit_header();
      emit_beat(KIND_LINK, OPCODE_TABLE[fr_op], 16'd0, 1'b0);
      if (fr_op != OP_TEST) begin
         emit_beat(KIND_LINK, fr_address[7:0], 16'd0, 1'b0);
         emit_beat(KIND_LINK, fr_address[15:8], 16'd0, 1'b0);
         if (fr_op == OP_RBLOCK || fr_op == OP_WBLOCK) begin
            emit_beat(KIND_LINK, fr_left[7:0], 16'd0, 1'b0);
            emit_beat(KIND_LINK, fr_left[15:8], 16'd0, 1'b0);
         end
      end
   endfunction

   function automatic void absorb_data_byte(input logic [7:0] value);
      int s;
      s = (int'(fr_sum_lo) + int'(value)) % FLETCHER_MOD;
      fr_sum_lo = s[7:0];
      s = (int'(fr_sum_hi) + int'(fr_sum_lo)) % FLETCHER_MOD;
      fr_sum_hi = s[7:0];
      fr_index = fr_index + 16'd1;
      fr_left  = fr_left - 16'd1;
      if (fr_left == 16'd0) fr_phase = AWAIT_SUM_LO;
   endfunction

   // Works out the response beats of one accepted request beat and queues them.
   // Returns whether the beat had any effect on the transfer.
   function automatic bit predict_framer_output(input logic [CMD_W-1:0] cmd,
                                                input logic [OP_W-1:0] op,
                                                input logic [15:0] addr,
                                                input logic [15:0] len,
                                                input logic [7:0] value);
      bit effect;
      rsp_beat_type tail;
      effect = 1'b1;
      beat_batch.delete();
      case (cmd)
         CMD_START: begin
            if (fr_phase != LINK_IDLE || op > OP_WBLOCK) begin
               effect = 1'b0;
            end else begin
               fr_op      = op;
               fr_address = addr;
               fr_left    = len;
               fr_index   = 16'd0;
               fr_sum_lo  = 8'd0;
               fr_sum_hi  = 8'd0;
               fr_held    = 8'd0;
               emit_header();
               if (op == OP_WBYTE) emit_beat(KIND_LINK, value, 16'd0, 1'b0);
               if (op == OP_RBLOCK || op == OP_WBLOCK)
                  fr_phase = (len == 16'd0) ? AWAIT_SUM_LO : BLOCK_DATA;
               else
                  fr_phase = AWAIT_REPLY;
            end
         end
         CMD_SEND: begin
            if (fr_phase != BLOCK_DATA || fr_op != OP_WBLOCK) begin
               effect = 1'b0;
            end else begin
               emit_beat(KIND_LINK, value, fr_index, 1'b0);
               absorb_data_byte(value);
            end
         end
         CMD_RECV: begin
            case (fr_phase)
               AWAIT_REPLY: begin
                  if (fr_op == OP_TEST) begin
                     // The final test reply is delivered as zero and closes the test.
                     if (int'(fr_index) + 1 >= REPLY_COUNT) begin
                        emit_beat(KIND_DELIVER, 8'd0, fr_index, 1'b0);
                        emit_beat(KIND_DONE, 8'd0, 16'd0, 1'b1);
                        fr_phase = LINK_IDLE;
                     end else begin
                        emit_beat(KIND_DELIVER, value, fr_index, 1'b0);
                        fr_index = fr_index + 16'd1;
                     end
                  end else if (fr_op == OP_RBYTE) begin
                     fr_held  = value;
                     fr_phase = AWAIT_ECHO;
                  end else begin
                     emit_beat(KIND_DONE, value, 16'd0, 1'b1);
                     fr_phase = LINK_IDLE;
                  end
               end
               AWAIT_ECHO: begin
                  // Two differing read replies make the framer send its header again.
                  if (value == fr_held) begin
                     emit_beat(KIND_DONE, value, 16'd0, 1'b1);
                     fr_phase = LINK_IDLE;
                  end else begin
                     emit_header();
                     fr_phase = AWAIT_REPLY;
                  end
               end
               BLOCK_DATA: begin
                  if (fr_op != OP_RBLOCK) begin
                     effect = 1'b0;
                  end else begin
                     emit_beat(KIND_DELIVER, value, fr_index, 1'b0);
                     absorb_data_byte(value);
                  end
               end
               AWAIT_SUM_LO: begin
                  fr_held  = value;
                  fr_phase = AWAIT_SUM_HI;
               end
               AWAIT_SUM_HI: begin
                  emit_beat(KIND_DONE, 8'd0, 16'd0,
                            (fr_sum_lo == fr_held && fr_sum_hi == value) ? 1'b1 : 1'b0);
                  fr_phase = LINK_IDLE;
               end
               default: effect = 1'b0;
            endcase
         end
         default: effect = 1'b0;
      endcase
      if (beat_batch.size() > 0) begin
         tail = beat_batch.pop_back();
         tail.last = 1'b1;
         beat_batch.push_back(tail);
         foreach (beat_batch[i]) awaited_rsp.push_back(beat_batch[i]);
      end
      return effect;
   endfunction

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [OP_W-1:0] op,
                            input logic [15:0] addr, input logic [15:0] len,
                            input logic [7:0] value);
      int gap;
      gap = tx_gapless ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.operation  <= op;
      req_chan.address    <= addr;
      req_chan.length     <= len;
      req_chan.byte_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      beats_sent++;
      if (predict_framer_output(cmd, op, addr, len, value)) effective_beats++;
   endtask

   // A data or link beat: the fields that the framer does not read carry random values.
   task automatic send_byte(input logic [CMD_W-1:0] cmd, input logic [7:0] value);
      send_beat(cmd, OP_W'($urandom_range(0, OP_HIGHEST)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), value);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_byte(CMD_SEND, 8'($urandom_range(0, 255)));
         1: send_byte(CMD_RECV, 8'($urandom_range(0, 255)));
         2: send_byte(CMD_UNUSED, 8'($urandom_range(0, 255)));
         default: send_beat(CMD_START,
                            OP_W'($urandom_range(int'(OP_WBLOCK) + 1, int'(OP_HIGHEST))),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic run_test_op(input logic [15:0] addr);
      send_beat(CMD_START, OP_TEST, addr, 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
      repeat (REPLY_COUNT) send_byte(CMD_RECV, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_read_byte(input logic [15:0] addr, input int mismatches);
      logic [7:0] reply;
      send_beat(CMD_START, OP_RBYTE, addr, 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
      repeat (mismatches) begin
         reply = 8'($urandom_range(0, 255));
         send_byte(CMD_RECV, reply);
         send_byte(CMD_RECV, reply ^ 8'($urandom_range(1, 255)));
      end
      reply = 8'($urandom_range(0, 255));
      send_byte(CMD_RECV, reply);
      send_byte(CMD_RECV, reply);
   endtask

   task automatic run_write_byte(input logic [15:0] addr, input logic [7:0] value);
      send_beat(CMD_START, OP_WBYTE, addr, 16'($urandom_range(0, 65535)), value);
      send_byte(CMD_RECV, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_block(input logic [OP_W-1:0] op, input logic [15:0] addr, input int len,
                            input bit corrupt, input bit noisy);
      logic [7:0]       check_lo;
      logic [7:0]       check_hi;
      logic [CMD_W-1:0] data_cmd;
      logic [CMD_W-1:0] stray_cmd;
      data_cmd  = (op == OP_WBLOCK) ? CMD_SEND : CMD_RECV;
      stray_cmd = (op == OP_WBLOCK) ? CMD_RECV : CMD_SEND;
      send_beat(CMD_START, op, addr, len[15:0], 8'($urandom_range(0, 255)));
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: send_byte(stray_cmd, 8'($urandom_range(0, 255)));
               1: send_byte(CMD_UNUSED, 8'($urandom_range(0, 255)));
               default: send_beat(CMD_START, OP_W'($urandom_range(0, OP_HIGHEST)),
                                  16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)),
                                  8'($urandom_range(0, 255)));
            endcase
         end
         send_byte(data_cmd, 8'($urandom_range(0, 255)));
      end
      check_lo = fr_sum_lo;
      check_hi = fr_sum_hi;
      if (corrupt) begin
         if ($urandom_range(0, 1) == 0)
            check_lo = check_lo ^ 8'($urandom_range(1, 255));
         else
            check_hi = check_hi ^ 8'($urandom_range(1, 255));
      end
      send_byte(CMD_RECV, check_lo);
      send_byte(CMD_RECV, check_hi);
   endtask

   task automatic test_directed_operations();
      run_test_op(16'h0000);
      run_read_byte(16'hFFFF, 1);
      run_write_byte(16'hA55A, 8'hFF);
      run_block(OP_RBLOCK, 16'h1234, 0, 1'b0, 1'b0);
      run_block(OP_WBLOCK, 16'hFFFF, 2, 1'b0, 1'b0);
      run_block(OP_RBLOCK, 16'h0001, 1, 1'b1, 1'b0);
   endtask

   task automatic test_ignored_items();
      send_byte(CMD_UNUSED, 8'hFF);
      send_byte(CMD_RECV, 8'h00);
      send_byte(CMD_SEND, 8'hFF);
      send_beat(CMD_START, OP_HIGHEST, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_beat(CMD_START, OP_WBLOCK + 3'd1, 16'h0000, 16'h0000, 8'h00);
      send_beat(CMD_START, OP_WBLOCK, 16'hFF00, 16'd1, 8'h00);
      send_beat(CMD_START, OP_RBYTE, 16'h5555, 16'hAAAA, 8'h55);
      send_byte(CMD_RECV, 8'hAA);
      send_byte(CMD_SEND, 8'hFE);
      send_byte(CMD_UNUSED, 8'h00);
      send_byte(CMD_SEND, 8'h01);
      send_byte(CMD_RECV, fr_sum_lo);
      send_byte(CMD_RECV, fr_sum_hi);
      run_block(OP_RBLOCK, 16'h8000, 4, 1'b0, 1'b1);
   endtask

   // The receiver holds off while data beats keep coming, so the job queue fills
   // and the request side has to stall.
   task automatic test_backpressure_fill();
      tx_gapless = 1'b1;
      rx_hold    = HOLD_CYCLES;
      run_block(OP_WBLOCK, 16'($urandom_range(0, 65535)), 40, 1'b0, 1'b0);
      tx_gapless = 1'b0;
   endtask

   task automatic test_large_block();
      tx_gapless = 1'b1;
      rx_gapless = 1'b1;
      run_block(OP_RBLOCK, 16'($urandom_range(0, 65535)), 20, 1'b0, 1'b0);
      run_block(OP_WBLOCK, 16'($urandom_range(0, 65535)), 12, 1'b1, 1'b0);
      tx_gapless = 1'b0;
      rx_gapless = 1'b0;
   endtask

   task automatic test_random_transfers();
      int first_count;
      int len;
      first_count = effective_beats;
      while (effective_beats - first_count < RANDOM_BEATS) begin
         tx_gapless = ($urandom_range(0, 3) == 0);
         rx_gapless = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
         case ($urandom_range(0, 9))
            0: send_noise();
            1: run_test_op(16'($urandom_range(0, 65535)));
            2: run_read_byte(16'($urandom_range(0, 65535)),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            3: run_write_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            4, 5, 6: run_block(OP_RBLOCK, 16'($urandom_range(0, 65535)), len,
                               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            default: run_block(OP_WBLOCK, 16'($urandom_range(0, 65535)), len,
                               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         endcase
      end
      tx_gapless = 1'b0;
      rx_gapless = 1'b0;
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failure_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      rsp_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         beats_checked++;
         if (awaited_rsp.size() == 0) begin
            $error("response beat with none awaited: kind %0d, byte %0h",
                   rsp_chan.kind, rsp_chan.out_byte);
            failure_count++;
         end else begin
            want = awaited_rsp.pop_front();
            compare_field("kind", 16'(want.kind), 16'(rsp_chan.kind));
            compare_field("out_byte", 16'(want.out_byte), 16'(rsp_chan.out_byte));
            compare_field("position", want.position, rsp_chan.position);
            compare_field("ok", 16'(want.ok), 16'(rsp_chan.ok));
            compare_field("last", 16'(want.last), 16'(rsp_chan.last));
         end
      end
   end

   initial begin : response_receiver
      int gap;
      int hold;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_hold > 0) begin
            hold    = rx_hold;
            rx_hold = 0;
            repeat (hold) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
         gap = rx_gapless ? 0 : $urandom_range(0, MAX_GAP);
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_START;
      req_chan.operation  = OP_TEST;
      req_chan.address    = 16'd0;
      req_chan.length     = 16'd0;
      req_chan.byte_value = 8'd0;
      tx_gapless          = 1'b0;
      rx_gapless          = 1'b0;
      rx_hold             = 0;
      beats_sent          = 0;
      effective_beats     = 0;
      beats_checked       = 0;
      failure_count       = 0;
      fr_phase            = LINK_IDLE;
      fr_op               = OP_TEST;
      fr_address          = 16'd0;
      fr_left             = 16'd0;
      fr_index            = 16'd0;
      fr_sum_lo           = 8'd0;
      fr_sum_hi           = 8'd0;
      fr_held             = 8'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_operations();
      test_ignored_items();
      test_backpressure_fill();
      test_large_block();
      test_random_transfers();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats, %0d of them acted on, and checked %0d response beats.",
               beats_sent, effective_beats, beats_checked);
      $display("Covered test, byte and block transfers, ignored beats, stalls and a long hold-off.");
      if (failure_count == 0)
         $display("[ram_link_transfer_framer] OK");
      else
         $display("[ram_link_transfer_framer] ERROR");
      $finish;
   end
endmodule
